// ===== design/beg_pkg.sv =====
`default_nettype none

package beg_pkg;

    // Geometry and sample format
    localparam int MAX_WIDTH   = 4096;
    localparam int SAMPLE_BITS = 12;
    localparam int ADDR_BITS   = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS  = 13;
    localparam int CMP_BITS    = (ADDR_BITS + 2 > WIDTH_BITS) ? ADDR_BITS + 2 : WIDTH_BITS + 1;
    localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = WIDTH_BITS;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GREEN_PARITY = 1'b1;
    localparam logic [WIDTH_BITS-1:0]     LINE_WIDTH_RESET = WIDTH_BITS'(MAX_WIDTH);

    // Input action codes
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;

    // Work queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [ADDR_BITS-1:0]   t_addr;

    typedef struct packed {
        logic [WIDTH_BITS-1:0] line_width;
        logic                  green_parity;
    } t_cfg;

    // One classified item: neighbourhood and framing, ready for the back end
    typedef struct packed {
        t_sample left;
        t_sample right;
        t_sample above;
        t_sample below;
        t_sample center;
        logic    green;
        logic    row_last;
        logic    frame_last;
    } t_work;

    typedef struct packed {
        logic                 nonempty;
        logic                 full;
        logic [QCNT_BITS-1:0] count;
    } t_q_status;

endpackage

`default_nettype wire

// ===== design/bayer_edge_sensing_green.sv =====
// A result passes stage one, the work queue and the output register in that order.
// Throughput: one item per cycle unless stalled; stores read on accept, written on retire.
// A result belongs to the pixel one row behind the input, so the first row gives none.
// Reset (i_rst_n low, synchronous): raster position, row count, queue and output clear;
// line_width returns to its maximum and green_parity to zero; row stores keep their contents.
`default_nettype none

module bayer_edge_sensing_green (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration write port
    input  wire                                  i_cfg_we,
    input  wire  [beg_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire  [beg_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    // input stream
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [beg_pkg::TDATA_BITS-1:0]       s_axis_tdata,   // [11:0] sample
    input  wire                                  s_axis_tuser,   // [0] action (1 = flush)
    // output stream
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [beg_pkg::TDATA_BITS-1:0]       m_axis_tdata,   // [11:0] green_value
    output logic                                 m_axis_tlast,   // row_last
    output logic                                 m_axis_tuser    // [0] frame_last
);
    import beg_pkg::*;

    t_cfg      r_cfg;
    t_work     front_work, queue_work;
    logic      front_push, queue_ready, queue_valid, back_pop;
    t_q_status q_status;
    t_sample   back_green;

    // Configuration registers: the user writes only while the block is idle; not enforced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_width   <= LINE_WIDTH_RESET;
            r_cfg.green_parity <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LINE_WIDTH:   r_cfg.line_width   <= i_cfg_data[WIDTH_BITS-1:0];
                REG_GREEN_PARITY: r_cfg.green_parity <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Front: accept, track the raster, read the row stores and gather the
    // four neighbours with border replication. Flushes before any row drop.
    beg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (s_axis_tvalid),
        .i_action      (s_axis_tuser),
        .i_sample      (s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_ready       (s_axis_tready),
        .o_work_valid  (front_push),
        .o_work        (front_work),
        .i_queue_ready (queue_ready)
    );

    // Queue: parts front from back so either side may stall on its own
    beg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (front_push),
        .i_data   (front_work),
        .o_ready  (queue_ready),
        .o_valid  (queue_valid),
        .o_data   (queue_work),
        .i_pop    (back_pop),
        .o_status (q_status)
    );

    // Back: keep green centres, else average the flatter pair (all four on ties), hold result
    beg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (queue_valid),
        .i_work       (queue_work),
        .o_pop        (back_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_green      (back_green),
        .o_row_last   (m_axis_tlast),
        .o_frame_last (m_axis_tuser)
    );

    assign m_axis_tdata = TDATA_BITS'(back_green);

`ifndef SYNTH
    // The front hands over only while the queue has room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_push |-> queue_ready)
        else $error("work item pushed into a full queue");

    // The queue never holds more than its depth
    a_queue_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("work queue count beyond its depth");

    // A frame ends only on the last pixel of a row
    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("frame end without row end");

    // The back end draws from the queue only when it holds an item
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_pop |-> q_status.nonempty)
        else $error("item drawn from an empty queue");
`endif

endmodule

`default_nettype wire

// ===== design/beg_front.sv =====
`default_nettype none

module beg_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  beg_pkg::t_cfg        i_cfg,
    input  wire                  i_valid,
    input  wire                  i_action,
    input  beg_pkg::t_sample     i_sample,
    output logic                 o_ready,
    output logic                 o_work_valid,
    output beg_pkg::t_work       o_work,
    input  wire                  i_queue_ready
);
    import beg_pkg::*;

    // Row stores
    t_sample r_upper  [MAX_WIDTH];
    t_sample r_middle [MAX_WIDTH];

    // Raster state
    t_addr       r_col, n_col;
    logic        r_row_par, n_row_par;
    logic [1:0]  r_rows, n_rows;

    // Stage one: item waiting for its store reads
    logic        r_s1_valid;
    t_addr       r_s1_col;
    logic        r_s1_last;
    logic        r_s1_flush;
    t_sample     r_s1_sample;
    logic        r_s1_emit;
    logic        r_s1_top;
    logic        r_s1_green;
    logic        r_s1_fwd;
    t_sample     r_s1_fwd_data;
    t_sample     r_mid_rd0, r_mid_rd1, r_up_rd;
    t_sample     r_prev_center;

    logic [CMP_BITS-1:0] w_raw, w_eff;
    logic        last, drop, accept, s1_move, green;
    t_addr       ra1;
    t_sample     center, stored;

    always_comb begin
        w_raw = CMP_BITS'(i_cfg.line_width);
        if (w_raw < CMP_BITS'(2))
            w_eff = CMP_BITS'(2);
        else if (w_raw > CMP_BITS'(MAX_WIDTH))
            w_eff = CMP_BITS'(MAX_WIDTH);
        else
            w_eff = w_raw;
    end

    assign last   = (CMP_BITS'(r_col) + CMP_BITS'(1)) >= w_eff;
    assign drop   = (i_action == ACT_FLUSH) && (r_rows == 2'd0);
    assign ra1    = r_col + ADDR_BITS'(1);
    assign green  = r_col[0] ^ ~r_row_par ^ i_cfg.green_parity;

    assign s1_move = r_s1_valid && (!r_s1_emit || i_queue_ready);
    assign o_ready = !r_s1_valid || s1_move;
    assign accept  = i_valid && o_ready;

    assign center = r_mid_rd0;
    assign stored = r_s1_flush ? center : r_s1_sample;

    // Raster position advance
    always_comb begin
        n_col     = r_col;
        n_row_par = r_row_par;
        n_rows    = r_rows;
        if (accept && !drop) begin
            if (last) begin
                n_col = '0;
                if (i_action == ACT_FLUSH) begin
                    n_rows    = 2'd0;
                    n_row_par = 1'b0;
                end else begin
                    n_row_par = ~r_row_par;
                    if (r_rows != 2'd2)
                        n_rows = r_rows + 2'd1;
                end
            end else begin
                n_col = r_col + ADDR_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row_par  <= 1'b0;
            r_rows     <= 2'd0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row_par <= n_row_par;
            r_rows    <= n_rows;
            if (accept)
                r_s1_valid <= !drop;
            else if (s1_move)
                r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col      <= r_col;
            r_s1_last     <= last;
            r_s1_flush    <= (i_action == ACT_FLUSH);
            r_s1_sample   <= i_sample;
            r_s1_emit     <= (r_rows != 2'd0);
            r_s1_top      <= (r_rows == 2'd1);
            r_s1_green    <= green;
            // stage one writes the right-hand entry in this very cycle
            r_s1_fwd      <= s1_move && (r_s1_col == ra1);
            r_s1_fwd_data <= stored;
        end
        if (s1_move)
            r_prev_center <= center;
    end

    // Store reads on accept, writes as stage one retires
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mid_rd0 <= r_middle[r_col];
            r_mid_rd1 <= r_middle[ra1];
            r_up_rd   <= r_upper[r_col];
        end
        if (s1_move) begin
            r_upper[r_s1_col]  <= center;
            r_middle[r_s1_col] <= stored;
        end
    end

    always_comb begin
        o_work.center     = center;
        o_work.left       = (r_s1_col == '0) ? center : r_prev_center;
        o_work.right      = r_s1_last ? center : (r_s1_fwd ? r_s1_fwd_data : r_mid_rd1);
        o_work.above      = r_s1_top ? center : r_up_rd;
        o_work.below      = r_s1_flush ? center : r_s1_sample;
        o_work.green      = r_s1_green;
        o_work.row_last   = r_s1_last;
        o_work.frame_last = r_s1_last && r_s1_flush;
    end

    assign o_work_valid = r_s1_valid && r_s1_emit && i_queue_ready;

endmodule

`default_nettype wire

// ===== design/beg_queue.sv =====
`default_nettype none

module beg_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  beg_pkg::t_work     i_data,
    output logic               o_ready,
    output logic               o_valid,
    output beg_pkg::t_work     o_data,
    input  wire                i_pop,
    output beg_pkg::t_q_status o_status
);
    import beg_pkg::*;

    t_work                r_slot [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic                 do_push, do_pop;

    // Full is judged on the registered count alone, so no path runs through
    assign o_ready = (r_count != QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push)
                r_wr_ptr <= (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : r_wr_ptr + QPTR_BITS'(1);
            if (do_pop)
                r_rd_ptr <= (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                      : r_rd_ptr + QPTR_BITS'(1);
            if (do_push && !do_pop)
                r_count <= r_count + QCNT_BITS'(1);
            else if (do_pop && !do_push)
                r_count <= r_count - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_slot[r_wr_ptr] <= i_data;
    end

    assign o_status.nonempty = o_valid;
    assign o_status.full     = !o_ready;
    assign o_status.count    = r_count;

endmodule

`default_nettype wire

// ===== design/beg_back.sv =====
`default_nettype none

module beg_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  beg_pkg::t_work   i_work,
    output logic             o_pop,
    output logic             o_valid,
    input  wire              i_ready,
    output beg_pkg::t_sample o_green,
    output logic             o_row_last,
    output logic             o_frame_last
);
    import beg_pkg::*;

    function automatic t_sample absdiff(input t_sample a, input t_sample b);
        absdiff = (a > b) ? a - b : b - a;
    endfunction

    logic                   r_valid;
    t_sample                r_green;
    logic                   r_row_last, r_frame_last;
    t_sample                dh, dv, v;
    logic [SAMPLE_BITS:0]   sum_h, sum_v;
    logic [SAMPLE_BITS+1:0] sum_all;
    logic                   load;

    always_comb begin
        dh      = absdiff(i_work.left, i_work.right);
        dv      = absdiff(i_work.above, i_work.below);
        sum_h   = {1'b0, i_work.left} + {1'b0, i_work.right};
        sum_v   = {1'b0, i_work.above} + {1'b0, i_work.below};
        sum_all = {1'b0, sum_h} + {1'b0, sum_v};
        if (i_work.green)
            v = i_work.center;
        else if (dh < dv)
            v = sum_h[SAMPLE_BITS:1];
        else if (dh > dv)
            v = sum_v[SAMPLE_BITS:1];
        else
            v = sum_all[SAMPLE_BITS+1:2];
    end

    assign load  = i_valid && (!r_valid || i_ready);
    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_valid <= 1'b0;
        else if (load)
            r_valid <= 1'b1;
        else if (i_ready)
            r_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_green      <= v;
            r_row_last   <= i_work.row_last;
            r_frame_last <= i_work.frame_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_green      = r_green;
    assign o_row_last   = r_row_last;
    assign o_frame_last = r_frame_last;

endmodule

`default_nettype wire
